// ===== sv/cki_pkg.sv =====
// ----------------------------------------------------------------------------
// cki_pkg: shared types and constants for the color keyframe interpolator
// Item and result words, status codes and the controller/datapath bundle.
// ----------------------------------------------------------------------------
package cki_pkg;

    localparam int MAX_KEYS_DEF = 16;
    localparam int AGE_W        = 17;
    localparam int COLOR_W      = 64;
    localparam int LIFE_W       = 16;
    localparam int CH_W         = 16;
    localparam logic [AGE_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        ST_COLOR    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_ADDED    = 2'd2,
        ST_REJECTED = 2'd3
    } t_status;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Result color selection.
    localparam logic [1:0] SEL_C0    = 2'd0;
    localparam logic [1:0] SEL_C1    = 2'd1;
    localparam logic [1:0] SEL_BLEND = 2'd2;
    localparam logic [1:0] SEL_ZERO  = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [AGE_W-1:0]   step_age;
        logic [COLOR_W-1:0] step_color;
        logic [LIFE_W-1:0]  life_left;
        logic [LIFE_W-1:0]  life_start;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [COLOR_W-1:0] out_color;
    } t_out_word;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture input word
        logic write_key;   // append keyframe
        logic age_start;   // start age division
        logic rd_first;    // read index 0
        logic rd_last;     // read last index
        logic rd_scan;     // read scan index
        logic scan_next;   // advance scan index
        logic cap_lo;      // capture low bracket from read data
        logic cap_hi;      // capture high bracket from read data
        logic frac_start;  // start factor division
        logic blend_step;  // one channel multiply
        logic set_out;     // latch result
        logic [1:0] out_sel; // 0 color0 1 color1 2 blend 3 zero
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic is_eval;
        logic empty;
        logic full;
        logic add_ok;
        logic div_done;
        logic le_rd;       // age <= read age
        logic ge_rd;       // age >= read age
        logic gt_rd;       // read age > age
        logic scan_end;    // scan index is last
        logic blend_done;
    } t_stat;

endpackage

// ===== sv/cki_ram.sv =====
// ----------------------------------------------------------------------------
// cki_ram: generic simple dual-port RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module cki_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== sv/cki_div.sv =====
// ----------------------------------------------------------------------------
// cki_div: restoring divider
// Computes floor((num << 16) / den) one quotient bit per cycle, 17 bits.
// ----------------------------------------------------------------------------
module cki_div
    import cki_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AGE_W-1:0] i_num,
    input  logic [AGE_W-1:0] i_den,
    output logic             o_done,
    output logic [AGE_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(AGE_W + 1);

    logic [AGE_W:0]   r_rem, n_rem;
    logic [AGE_W-1:0] r_quot, n_quot;
    logic [AGE_W-1:0] r_den;
    logic [AGE_W-1:0] r_numsh;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [AGE_W+1:0] w_trial;

    // Dividend is num then 16 zeros; num[0] enters first, its top bits preloaded.
    always_comb begin
        w_trial = {r_rem, r_numsh[AGE_W-1]};
        if (w_trial >= {2'b00, r_den}) begin
            n_rem  = (AGE_W+1)'(w_trial - {2'b00, r_den});
            n_quot = {r_quot[AGE_W-2:0], 1'b1};
        end else begin
            n_rem  = w_trial[AGE_W:0];
            n_quot = {r_quot[AGE_W-2:0], 1'b0};
        end
    end

    // The first dividend bit after num's 17 bits would be zeros; since num is
    // below 2^17 and only the low 17 quotient bits matter, shift num through
    // with 16 zeros appended by starting the remainder from num >> 1 trick:
    // here the remainder is preloaded with the top of num directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(AGE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // Quotient of (num<<16)/den with num<=den fits in 17 bits, so the
            // integer part num/den is at most 1: preload num>>1 as remainder.
            r_rem   <= {2'b00, i_num[AGE_W-1:1]};
            r_numsh <= {i_num[0], 16'd0};
            r_den   <= i_den;
            r_quot  <= '0;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_quot  <= n_quot;
            r_numsh <= {r_numsh[AGE_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== sv/cki_datapath.sv =====
// ----------------------------------------------------------------------------
// cki_datapath: keyframe storage and arithmetic
// Key memories, age and factor division, bracket registers and channel blend.
// ----------------------------------------------------------------------------
module cki_datapath
    import cki_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_word o_out
);
    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    t_in_word           r_in;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_scan, n_raddr;
    logic [AGE_W-1:0]   r_age, r_a0, r_f, r_last_age;
    logic [COLOR_W-1:0] r_c0, r_c1, r_blend;
    logic [1:0]         r_ch;
    logic               r_age_phase, r_blend_done;
    logic [AGE_W-1:0]   w_rd_age;
    logic [COLOR_W-1:0] w_rd_color;
    logic               w_div_start, w_div_done;
    logic [AGE_W-1:0]   w_num, w_den, w_quot;
    logic [CH_W-1:0]    w_a, w_b;
    logic [2*CH_W:0]    w_mix;
    t_out_word          r_out;
    logic [IDX_W-1:0]   w_last;

    assign w_last = IDX_W'(r_count - 1'b1);

    always_comb begin
        n_raddr = '0;
        if (i_cmd.rd_scan)  n_raddr = r_scan;
        if (i_cmd.rd_first) n_raddr = '0;
        if (i_cmd.rd_last)  n_raddr = w_last;
    end

    cki_ram #(.WIDTH(AGE_W), .DEPTH(MAX_KEYS)) u_age_ram (
        .i_clk(i_clk), .i_we(i_cmd.write_key), .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(r_in.step_age), .i_raddr(n_raddr), .o_rdata(w_rd_age));
    cki_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_KEYS)) u_color_ram (
        .i_clk(i_clk), .i_we(i_cmd.write_key), .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(r_in.step_color), .i_raddr(n_raddr), .o_rdata(w_rd_color));

    // One divider serves both the age and the factor division. The factor
    // division starts in the cycle that the upper bracket age is on the read
    // port, so its width is taken straight from the read data.
    assign w_div_start = i_cmd.age_start | i_cmd.frac_start;
    always_comb begin
        if (i_cmd.age_start) begin
            w_num = (r_in.life_left > r_in.life_start) ? {1'b0, r_in.life_start}
                                                       : {1'b0, r_in.life_left};
            w_den = {1'b0, r_in.life_start};
        end else begin
            w_num = r_age - r_a0;
            w_den = w_rd_age - r_a0;
        end
    end

    cki_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_div_done), .o_quot(w_quot));

    assign w_a   = r_c0[COLOR_W-1 -: CH_W];
    assign w_b   = r_c1[COLOR_W-1 -: CH_W];
    // c0 + (c1 - c0) * f / 65536 with floor, using signed difference.
    always_comb begin
        logic signed [CH_W:0]     d;
        logic signed [2*CH_W+1:0] p;
        d = $signed({1'b0, w_b}) - $signed({1'b0, w_a});
        p = d * $signed({1'b0, r_f[CH_W-1:0]});
        w_mix = (2*CH_W+1)'($signed({1'b0, w_a, 16'd0}) + p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_age_phase  <= 1'b0;
            r_blend_done <= 1'b0;
        end else begin
            r_blend_done <= 1'b0;
            if (i_cmd.write_key) r_count <= r_count + 1'b1;
            if (i_cmd.age_start) r_age_phase <= 1'b1;
            if (i_cmd.frac_start) r_age_phase <= 1'b0;
            if (i_cmd.blend_step && r_ch == 2'd3) r_blend_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
            r_scan <= IDX_W'(1);
            r_ch <= '0;
        end
        if (i_cmd.write_key) r_last_age <= r_in.step_age;
        if (w_div_done && r_age_phase) begin
            r_age <= (r_in.life_start == '0) ? ONE_Q16 : ONE_Q16 - w_quot;
        end
        if (w_div_done && !r_age_phase) begin
            r_f <= (w_quot > AGE_W'(16'hFFFF)) ? AGE_W'(16'hFFFF) : w_quot;
        end
        if (i_cmd.scan_next) r_scan <= r_scan + 1'b1;
        if (i_cmd.cap_lo) begin
            r_a0 <= w_rd_age;
            r_c0 <= w_rd_color;
        end
        if (i_cmd.cap_hi) begin
            r_c1 <= w_rd_color;
        end
        if (i_cmd.blend_step) begin
            r_blend <= {r_blend[COLOR_W-CH_W-1:0], w_mix[2*CH_W-1:CH_W]};
            r_c0    <= {r_c0[COLOR_W-CH_W-1:0], CH_W'(0)};
            r_c1    <= {r_c1[COLOR_W-CH_W-1:0], CH_W'(0)};
            r_ch    <= r_ch + 1'b1;
        end
        if (i_cmd.set_out) begin
            r_out.status <= i_cmd.out_status;
            case (i_cmd.out_sel)
                SEL_C0:    r_out.out_color <= r_c0;
                SEL_C1:    r_out.out_color <= r_c1;
                SEL_BLEND: r_out.out_color <= r_blend;
                default:   r_out.out_color <= '0;
            endcase
        end
    end

    assign o_stat.is_eval    = (r_in.cmd == CMD_EVAL);
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count == CNT_W'(MAX_KEYS));
    assign o_stat.add_ok     = (r_count == '0) || (r_in.step_age > r_last_age);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.le_rd      = (r_age <= w_rd_age);
    assign o_stat.ge_rd      = (r_age >= w_rd_age);
    assign o_stat.gt_rd      = (w_rd_age > r_age);
    assign o_stat.scan_end   = (r_scan == w_last);
    assign o_stat.blend_done = r_blend_done;
    assign o_out = r_out;
endmodule

// ===== sv/cki_ctrl.sv =====
// ----------------------------------------------------------------------------
// cki_ctrl: controller for the color keyframe interpolator
// Sequences add, age division, bracket search, factor division and blend.
// ----------------------------------------------------------------------------
module cki_ctrl
    import cki_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DEC   = 12'b000000000010,
        S_AGE   = 12'b000000000100,
        S_RDF   = 12'b000000001000,
        S_CHKF  = 12'b000000010000,
        S_CHKL  = 12'b000000100000,
        S_SCAN  = 12'b000001000000,
        S_CHKS  = 12'b000010000000,
        S_RDHI  = 12'b000100000000,
        S_FRAC  = 12'b001000000000,
        S_BLEND = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;
    logic   r_first;
    logic   w_accept, w_take;

    assign w_take   = r_valid && !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_valid  = r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (!r_valid || w_take) begin
                    if (!i_stat.is_eval) begin
                        o_cmd.set_out = 1'b1;
                        o_cmd.out_sel = SEL_ZERO;
                        if (!i_stat.full && i_stat.add_ok) begin
                            o_cmd.write_key  = 1'b1;
                            o_cmd.out_status = ST_ADDED;
                        end else begin
                            o_cmd.out_status = ST_REJECTED;
                        end
                        n_state = S_IDLE;
                    end else if (i_stat.empty) begin
                        o_cmd.set_out    = 1'b1;
                        o_cmd.out_sel    = SEL_ZERO;
                        o_cmd.out_status = ST_EMPTY;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.age_start = 1'b1;
                        n_state = S_AGE;
                    end
                end
            end
            S_AGE: if (i_stat.div_done) begin
                o_cmd.rd_first = 1'b1;
                n_state = S_RDF;
            end
            S_RDF: begin
                o_cmd.rd_first = 1'b1;
                n_state = S_CHKF;
            end
            S_CHKF: begin
                // Read data is key 0; key last is being read.
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_last = 1'b1;
                if (i_stat.le_rd) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CHKL;
                end
            end
            S_CHKL: begin
                o_cmd.cap_hi = 1'b1;
                o_cmd.rd_scan = 1'b1;
                if (i_stat.ge_rd) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CHKS;
                end
            end
            S_CHKS: begin
                // Read data is key at scan index.
                if (i_stat.gt_rd || i_stat.scan_end) begin
                    o_cmd.cap_hi = 1'b1;
                    o_cmd.frac_start = 1'b1;
                    n_state = S_FRAC;
                end else begin
                    o_cmd.cap_lo = 1'b1;
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_scan = 1'b1;
                n_state = S_CHKS;
            end
            S_FRAC: if (i_stat.div_done) n_state = S_BLEND;
            S_BLEND: begin
                o_cmd.blend_step = 1'b1;
                n_state = S_RDHI;
            end
            S_RDHI: begin
                if (i_stat.blend_done) begin
                    o_cmd.set_out = 1'b1;
                    o_cmd.out_sel = SEL_BLEND;
                    o_cmd.out_status = ST_COLOR;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.blend_step = 1'b1;
                end
            end
            S_OUT: begin
                // Clamp cases: first color from lo, last color from hi.
                o_cmd.set_out = 1'b1;
                o_cmd.out_status = ST_COLOR;
                o_cmd.out_sel = r_first ? SEL_C0 : SEL_C1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Track which clamp applies in S_OUT.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHKF) r_first <= i_stat.le_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.set_out) r_valid <= 1'b1;
            else if (w_take)   r_valid <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_set_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.set_out |-> (!r_valid || w_take || r_state != S_DEC))
        else $error("result overwritten");
    a_one_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.age_start && o_cmd.frac_start)) else $error("two divisions");
`endif
endmodule

// ===== sv/color_keyframe_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// color_keyframe_interpolator_top: RGBA keyframe table with linear blend
// Add words append keyframes; evaluate words return the interpolated color.
// ----------------------------------------------------------------------------
// One word is processed at a time and the input stalls until its result has
// been produced. An evaluation of a non-empty table runs the age division
// (17 quotient bits, one a cycle) and then reads the first and last keyframe
// over the key memory's single read port. An interpolated color then adds the
// bracket search over the keyframes, the factor division and the channel
// multiplies. A result still waiting on the output holds the next word in
// decode.
module color_keyframe_interpolator_top
    import cki_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);
    t_cmd  w_cmd;
    t_stat w_stat;

    cki_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_stat(w_stat), .o_cmd(w_cmd));

    cki_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_data), .i_cmd(w_cmd),
        .o_stat(w_stat), .o_out(o_data));
endmodule

// ===== verif/tb_color_keyframe_interpolator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_keyframe_interpolator_top: self-checking bench for the interpolator
// Builds a keyframe table of varied spacing, evaluates particles against it and
// compares every result word with a behavioral prediction of the table.
// ----------------------------------------------------------------------------
module tb_color_keyframe_interpolator_top
    import cki_pkg::*;
();

    localparam int NKEYS = MAX_KEYS_DEF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_data;

    color_keyframe_interpolator_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // Predicted copy of the keyframe table.
    int unsigned        tbl_count;
    logic [AGE_W-1:0]   tbl_age[NKEYS];
    logic [COLOR_W-1:0] tbl_color[NKEYS];

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        error_count;
    bit        stim_done;
    bit        quiet_mode;
    bit        pause_send;
    int        hold_cycles;
    int        send_idle;
    int        recv_idle;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic logic [AGE_W-1:0] particle_age(logic [15:0] life, logic [15:0] start);
        logic [31:0] l;
        if (start == 0) begin
            return ONE_Q16;
        end
        l = 32'(life);
        if (life > start) begin
            l = 32'(start);
        end
        return 17'(32'h10000 - 32'((64'(l) << 16) / 64'(start)));
    endfunction

    function automatic logic [COLOR_W-1:0] mix_colors(logic [COLOR_W-1:0] c0,
                                                    logic [COLOR_W-1:0] c1,
                                                    logic [16:0] f);
        logic [COLOR_W-1:0] res;
        logic [47:0]        v;
        res = '0;
        for (int ch = 0; ch < 4; ch++) begin
            v = (48'(c0[ch*16 +: 16]) * (48'h10000 - 48'(f)) +
                 48'(c1[ch*16 +: 16]) * 48'(f)) >> 16;
            res[ch*16 +: 16] = v[15:0];
        end
        return res;
    endfunction

    // Applies one word to the predicted table and returns its result word.
    function automatic t_out_word apply_word(t_in_word w);
        t_out_word        r;
        logic [AGE_W-1:0] age;
        logic [AGE_W-1:0] a0;
        logic [AGE_W-1:0] a1;
        logic [16:0]      f;
        int unsigned      i;
        int unsigned      last;
        r.status    = ST_COLOR;
        r.out_color = '0;
        if (w.cmd == CMD_ADD) begin
            if (tbl_count >= NKEYS ||
                (tbl_count > 0 && !(w.step_age > tbl_age[tbl_count-1]))) begin
                r.status = ST_REJECTED;
            end else begin
                tbl_age[tbl_count]   = w.step_age;
                tbl_color[tbl_count] = w.step_color;
                tbl_count++;
                r.status = ST_ADDED;
            end
            return r;
        end
        if (tbl_count == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        age  = particle_age(w.life_left, w.life_start);
        last = tbl_count - 1;
        if (age <= tbl_age[0]) begin
            r.out_color = tbl_color[0];
        end else if (age >= tbl_age[last]) begin
            r.out_color = tbl_color[last];
        end else begin
            for (i = 1; i < last; i++) begin
                if (tbl_age[i] > age) begin
                    break;
                end
            end
            a0 = tbl_age[i-1];
            a1 = tbl_age[i];
            f  = 17'((64'(age - a0) << 16) / 64'(a1 - a0));
            if (f > 17'hFFFF) begin
                f = 17'hFFFF;
            end
            r.out_color = mix_colors(tbl_color[i-1], tbl_color[i], f);
        end
        return r;
    endfunction

    function automatic logic [63:0] rand_color();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_word add_word(logic [AGE_W-1:0] age, logic [COLOR_W-1:0] col);
        t_in_word w;
        w.cmd        = CMD_ADD;
        w.step_age   = age;
        w.step_color = col;
        w.life_left  = 16'($urandom);
        w.life_start = 16'($urandom);
        return w;
    endfunction

    function automatic t_in_word eval_word(logic [15:0] life, logic [15:0] start);
        t_in_word w;
        w.cmd        = CMD_EVAL;
        w.step_age   = 17'($urandom);
        w.step_color = {$urandom, $urandom};
        w.life_left  = life;
        w.life_start = start;
        return w;
    endfunction

    task automatic queue_word(t_in_word w);
        pending_words = {pending_words, w};
    endtask

    // A reset clears the table, so new tables are built by pushing the old one
    // full and then starting over is impossible; instead tables only grow.
    // Random tables are therefore built once per run with random spacing, and
    // the rejection paths are exercised throughout.
    task automatic build_directed();
        queue_word(eval_word(16'd5, 16'd10));          // empty table
        queue_word(add_word(17'd0, 64'h0));
        queue_word(add_word(17'd0, 64'hFFFF_FFFF_FFFF_FFFF)); // equal age
        queue_word(eval_word(16'd0, 16'd0));           // zero start
        queue_word(add_word(17'h08000, 64'hFFFF_FFFF_FFFF_FFFF));
        queue_word(add_word(17'h04000, 64'h1234_5678_9ABC_DEF0)); // out of order
        queue_word(eval_word(16'hFFFF, 16'hFFFF));     // age zero
        queue_word(eval_word(16'hFFFF, 16'd3));        // life above start
        queue_word(eval_word(16'd1, 16'd3));
        queue_word(eval_word(16'd0, 16'hFFFF));
        queue_word(add_word(17'h10000, 64'h0000_FFFF_0000_FFFF));
        queue_word(eval_word(16'd3, 16'd4));
        queue_word(eval_word(16'd1, 16'd4));
        queue_word(eval_word(16'd0, 16'd7));
    endtask

    task automatic build_random();
        logic [AGE_W-1:0] last_age;
        int               n;
        last_age = 17'h10000;
        // Fill the rest of the table with widely and tightly spaced keys.
        while (pending_words.size() < 60) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_word(add_word(17'($urandom), rand_color()));
            end else begin
                n = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 6000);
                if (32'(last_age) + n <= 32'h1FFFF) begin
                    last_age = last_age + 17'(n);
                end else begin
                    last_age = 17'h1FFFF;
                end
                queue_word(add_word(last_age, rand_color()));
            end
            queue_word(eval_word(16'($urandom), 16'($urandom)));
        end
        queue_word(add_word(17'h1FFFF, rand_color()));
        queue_word(add_word(17'h1FFFF, rand_color()));
        for (int k = 0; k < 1450; k++) begin
            case ($urandom_range(0, 9))
                0: queue_word(add_word(17'($urandom), rand_color()));
                1: queue_word(eval_word(16'($urandom), 16'($urandom_range(0, 3))));
                2: queue_word(eval_word(16'hFFFF, 16'($urandom)));
                default: begin
                    n = $urandom_range(1, 65535);
                    queue_word(eval_word(16'($urandom_range(0, n)), 16'(n)));
                end
            endcase
        end
    endtask

    initial begin
        error_count = 0;
        stim_done   = 1'b0;
        quiet_mode  = 1'b0;
        pause_send  = 1'b0;
        hold_cycles = 0;
        tbl_count   = 0;
        i_rst_n     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        build_directed();
        wait (pending_words.size() == 0);
        // Receiver holds off long enough for the block to back up its input.
        build_random();
        hold_cycles = 400;
        wait (pending_words.size() < 1400);
        // Sender pauses until the block has drained.
        pause_send = 1'b1;
        wait (expected_words.size() == 0);
        pause_send = 1'b0;
        wait (pending_words.size() < 200);
        quiet_mode = 1'b1;
        wait (pending_words.size() == 0 && !i_valid);
        wait (expected_words.size() == 0);
        repeat (100) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Driver: a word is taken off the queue only when the previous one went in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_data    <= '0;
            send_idle <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (send_idle > 0) begin
                send_idle <= send_idle - 1;
                i_valid   <= 1'b0;
            end else if (!pause_send && pending_words.size() > 0) begin
                i_data  <= pending_words[0];
                i_valid <= 1'b1;
                expected_words = {expected_words, apply_word(pending_words.pop_front())};
                if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                    send_idle <= $urandom_range(1, 10);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall generation.
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            recv_idle <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %h", o_data);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_data.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, o_data.status);
                        error_count++;
                    end
                    if (o_data.out_color !== want.out_color) begin
                        $error("out_color: expected %h actual %h",
                               want.out_color, o_data.out_color);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_stall     <= 1'b1;
            end else if (recv_idle > 0) begin
                recv_idle <= recv_idle - 1;
                i_stall   <= 1'b1;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                recv_idle <= $urandom_range(0, 9);
                i_stall   <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
